// File: rtl/y2p_pkg.sv
package y2p_pkg;

  // Frame geometry limits.
  localparam int MaxPairs = 1024;
  localparam int MaxRows  = 2048;
  localparam int PairW    = $clog2(MaxPairs);
  localparam int RowW     = $clog2(MaxRows);

  // Fixed field widths of the channels and registers.
  localparam int PixW      = 8;
  localparam int WordW     = 4 * PixW;
  localparam int DestRowW  = 11;
  localparam int DestPairW = 10;
  localparam int PairsRegW = 11;
  localparam int RowsRegW  = 12;
  localparam int CfgW      = 12;
  localparam int CfgIdxW   = 3;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QLvlW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegPlanar = 3'd0,
    RegUyvy   = 3'd1,
    RegPairs  = 3'd2,
    RegRows   = 3'd3,
    RegFlip   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0]      luma_left;
    logic [PixW-1:0]      luma_right;
    logic [PixW-1:0]      chroma_u;
    logic [PixW-1:0]      chroma_v;
    logic                 uyvy;
    logic [DestRowW-1:0]  dest_row;
    logic [DestPairW-1:0] dest_pair;
    logic                 frame_end;
  } y2p_entry_t;

endpackage

// File: rtl/y2p_if.sv
interface y2p_pair_if
  import y2p_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] luma_left;
  logic [PixW-1:0] luma_right;
  logic [PixW-1:0] chroma_u;
  logic [PixW-1:0] chroma_v;

  modport source (output valid, luma_left, luma_right, chroma_u, chroma_v, input ready);
  modport sink   (input valid, luma_left, luma_right, chroma_u, chroma_v, output ready);
endinterface

interface y2p_word_if
  import y2p_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WordW-1:0]     packed_word;
  logic [DestRowW-1:0]  dest_row;
  logic [DestPairW-1:0] dest_pair;
  logic                 frame_end;

  modport source (output valid, packed_word, dest_row, dest_pair, frame_end, input ready);
  modport sink   (input valid, packed_word, dest_row, dest_pair, frame_end, output ready);
endinterface

// File: rtl/y2p_ram.sv
module y2p_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/y2p_front.sv
module y2p_front
  import y2p_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  y2p_pair_if.sink           pair_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [QLvlW-1:0]   q_level_i,
  output logic               push_o,
  output y2p_entry_t         push_entry_o
);

  logic                 planar_q;
  logic                 uyvy_q;
  logic [PairsRegW-1:0] pairs_q;
  logic [RowsRegW-1:0]  rows_q;
  logic                 flip_q;

  logic [PairW-1:0] pair_cnt_q, pair_cnt_d;
  logic [RowW-1:0]  row_cnt_q, row_cnt_d;

  logic [PairW-1:0] pair_last;
  logic [RowW-1:0]  row_last_idx;
  logic             row_last;
  logic             frame_last;
  logic [RowW-1:0]  drow;
  logic             accept;
  logic             odd_row;
  logic             mem_we;
  logic             mem_re;
  logic [15:0]      mem_rdata;

  // Item in flight while its chroma is read from the line buffer.
  logic       s1_valid_q;
  logic       s1_use_mem_q;
  y2p_entry_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planar_q <= 1'b1;
      uyvy_q   <= 1'b0;
      pairs_q  <= PairsRegW'(320);
      rows_q   <= RowsRegW'(480);
      flip_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPlanar: planar_q <= cfg_wdata_i[0];
        RegUyvy:   uyvy_q   <= cfg_wdata_i[0];
        RegPairs:  pairs_q  <= cfg_wdata_i[PairsRegW-1:0];
        RegRows:   rows_q   <= cfg_wdata_i[RowsRegW-1:0];
        RegFlip:   flip_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Zero sizes act as one, oversized ones saturate at the limits.
  always_comb begin
    if (pairs_q == '0) begin
      pair_last = '0;
    end else if (32'(pairs_q) > MaxPairs) begin
      pair_last = PairW'(MaxPairs - 1);
    end else begin
      pair_last = PairW'(pairs_q - PairsRegW'(1));
    end
    if (rows_q == '0) begin
      row_last_idx = '0;
    end else if (32'(rows_q) > MaxRows) begin
      row_last_idx = RowW'(MaxRows - 1);
    end else begin
      row_last_idx = RowW'(rows_q - RowsRegW'(1));
    end
  end

  assign row_last   = pair_cnt_q >= pair_last;
  assign frame_last = row_last && (row_cnt_q >= row_last_idx);
  assign drow       = flip_q ? (row_last_idx - row_cnt_q) : row_cnt_q;
  assign odd_row    = row_cnt_q[0];

  // Room is reserved for the in-flight item, so it never has to wait.
  assign pair_i.ready = (32'(q_level_i) + 32'(s1_valid_q)) < QDepth;
  assign accept       = pair_i.valid && pair_i.ready;
  assign mem_we       = accept && planar_q && !odd_row;
  assign mem_re       = accept && planar_q && odd_row;

  always_comb begin
    pair_cnt_d = pair_cnt_q;
    row_cnt_d  = row_cnt_q;
    if (accept) begin
      if (row_last) begin
        pair_cnt_d = '0;
        row_cnt_d  = frame_last ? '0 : row_cnt_q + RowW'(1);
      end else begin
        pair_cnt_d = pair_cnt_q + PairW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_cnt_q   <= '0;
      row_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      s1_use_mem_q <= 1'b0;
    end else begin
      pair_cnt_q   <= pair_cnt_d;
      row_cnt_q    <= row_cnt_d;
      s1_valid_q   <= accept;
      s1_use_mem_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.luma_left  <= pair_i.luma_left;
      s1_q.luma_right <= pair_i.luma_right;
      s1_q.chroma_u   <= pair_i.chroma_u;
      s1_q.chroma_v   <= pair_i.chroma_v;
      s1_q.uyvy       <= uyvy_q;
      s1_q.dest_row   <= DestRowW'(drow);
      s1_q.dest_pair  <= DestPairW'(pair_cnt_q);
      s1_q.frame_end  <= frame_last;
    end
  end

  // Chroma line buffer: U in the low byte, V in the high byte.
  y2p_ram #(
    .Width (2 * PixW),
    .Depth (MaxPairs)
  ) u_chroma_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pair_cnt_q),
    .wdata_i ({pair_i.chroma_v, pair_i.chroma_u}),
    .re_i    (mem_re),
    .raddr_i (pair_cnt_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    push_entry_o = s1_q;
    if (s1_use_mem_q) begin
      push_entry_o.chroma_u = mem_rdata[PixW-1:0];
      push_entry_o.chroma_v = mem_rdata[2*PixW-1:PixW];
    end
  end

  assign push_o = s1_valid_q;

endmodule

// File: rtl/y2p_queue.sv
module y2p_queue
  import y2p_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  y2p_entry_t       push_entry_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output y2p_entry_t       head_o,
  output logic [QLvlW-1:0] level_o
);

  y2p_entry_t       slots_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QLvlW-1:0] level_q;
  logic             do_pop;

  assign head_valid_o = level_q != '0;
  assign head_o       = slots_q[rd_ptr_q];
  assign level_o      = level_q;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        level_q <= level_q + QLvlW'(1);
      end else if (!push_i && do_pop) begin
        level_q <= level_q - QLvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/y2p_back.sv
module y2p_back
  import y2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  y2p_entry_t head_i,
  output logic       pop_o,
  y2p_word_if.source word_o
);

  logic                 out_valid_q;
  logic [WordW-1:0]     word_q;
  logic [DestRowW-1:0]  row_q;
  logic [DestPairW-1:0] pair_q;
  logic                 end_q;
  logic [WordW-1:0]     word_d;

  // First byte sits in the low bits of the word.
  assign word_d = head_i.uyvy
                ? {head_i.luma_right, head_i.chroma_v, head_i.luma_left, head_i.chroma_u}
                : {head_i.chroma_v, head_i.luma_right, head_i.chroma_u, head_i.luma_left};

  assign pop_o = head_valid_i && (!out_valid_q || word_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (word_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= word_d;
      row_q  <= head_i.dest_row;
      pair_q <= head_i.dest_pair;
      end_q  <= head_i.frame_end;
    end
  end

  assign word_o.valid       = out_valid_q;
  assign word_o.packed_word = word_q;
  assign word_o.dest_row    = row_q;
  assign word_o.dest_pair   = pair_q;
  assign word_o.frame_end   = end_q;

endmodule

// File: rtl/yuv420_to_packed_422_converter_core.sv
// Pixel-pair to packed 4:2:2 converter.
// The pair_i channel takes one horizontal pixel pair per word in raster
// order: left and right luma plus one U and one V sample. The word_o channel
// returns one 32-bit YUY2 or UYVY word per pair together with its
// destination row, its pair index within the row and a frame end mark.
// Both channels use a valid/ready handshake.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle; a write takes effect on the next pair.
// In planar mode even rows store their chroma in a line buffer of 1024
// entries and odd rows read it back by pair position.
// A pair accepted passes through the s1 register, a queue slot and the
// output register before its word is valid on word_o.
// While pair_i.ready is high one pair is accepted per cycle; the line
// buffer has one write or one read per cycle, and a four-entry queue sits
// between the input side and the output register.
// When the receiver stalls, the queue fills and pair_i.ready falls once
// the queue and the pair in flight in the s1 register use all four slots.
// Reset clears the row and pair counters and sets the registers to planar
// YUY2, 320 pairs by 480 rows, no flip; the line buffer is not cleared.
module yuv420_to_packed_422_converter_core
  import y2p_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  y2p_pair_if.sink           pair_i,
  y2p_word_if.source         word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic             push;
  y2p_entry_t       push_entry;
  logic             pop;
  logic             head_valid;
  y2p_entry_t       head;
  logic [QLvlW-1:0] q_level;

  y2p_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_level_i    (q_level),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  y2p_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .level_o      (q_level)
  );

  y2p_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .word_o       (word_o)
  );

endmodule

// File: tb/packed_word_checker.sv
`timescale 1ns / 100ps

module packed_word_checker
  import y2p_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  y2p_pair_if                pair_i,
  y2p_word_if                word_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        error_count_o,
  output int unsigned        words_pending_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned ResetPairs  = 320;
  localparam int unsigned ResetRows   = 480;

  typedef struct packed {
    logic [WordW-1:0]     packed_word;
    logic [DestRowW-1:0]  dest_row;
    logic [DestPairW-1:0] dest_pair;
    logic                 frame_end;
  } packed_result_t;

  logic                 planar_src;
  logic                 uyvy_order;
  logic                 flip_rows;
  logic [PairsRegW-1:0] row_pairs;
  logic [RowsRegW-1:0]  frame_height;
  // U in the low byte, V in the high byte.
  logic [2*PixW-1:0]    chroma_line [MaxPairs];
  int unsigned          pair_pos;
  int unsigned          row_pos;
  int unsigned          mismatches = 0;
  int unsigned          words_seen = 0;
  packed_result_t       expected_words [$];

  function automatic int unsigned clamp_extent(input int unsigned value,
                                               input int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic packed_result_t convert_pair(input logic [PixW-1:0] yl,
                                                  input logic [PixW-1:0] yr,
                                                  input logic [PixW-1:0] cu,
                                                  input logic [PixW-1:0] cv);
    int unsigned    width;
    int unsigned    height;
    logic [PixW-1:0] u;
    logic [PixW-1:0] v;
    logic           row_done;
    packed_result_t res;
    width  = clamp_extent(row_pairs, MaxPairs);
    height = clamp_extent(frame_height, MaxRows);
    u = cu;
    v = cv;
    // Even planar rows store their chroma, odd ones reuse it by position.
    if (planar_src && pair_pos < MaxPairs) begin
      if (row_pos[0] == 1'b0) begin
        chroma_line[pair_pos] = {cv, cu};
      end else begin
        {v, u} = chroma_line[pair_pos];
      end
    end
    res.packed_word = uyvy_order ? {yr, v, yl, u} : {v, yr, u, yl};
    // The subtraction wraps when the height shrank below the current row.
    res.dest_row  = flip_rows ? DestRowW'(height - 1 - row_pos) : DestRowW'(row_pos);
    res.dest_pair = DestPairW'(pair_pos);
    row_done      = pair_pos >= width - 1;
    res.frame_end = row_done && row_pos >= height - 1;
    if (row_done) begin
      pair_pos = 0;
      row_pos  = res.frame_end ? 0 : row_pos + 1;
    end else begin
      pair_pos++;
    end
    return res;
  endfunction

  function automatic void check_word();
    packed_result_t want;
    packed_result_t got;
    got = {word_i.packed_word, word_i.dest_row, word_i.dest_pair, word_i.frame_end};
    words_seen++;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("word %0d arrived with nothing expected: %h row %0d pair %0d end %b",
                 words_seen, got.packed_word, got.dest_row, got.dest_pair, got.frame_end);
      return;
    end
    want = expected_words.pop_front();
    if (got.packed_word !== want.packed_word || got.dest_row !== want.dest_row ||
        got.dest_pair !== want.dest_pair || got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("word %0d: expected %h row %0d pair %0d end %b, got %h row %0d pair %0d end %b",
                 words_seen, want.packed_word, want.dest_row, want.dest_pair, want.frame_end,
                 got.packed_word, got.dest_row, got.dest_pair, got.frame_end);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planar_src   = 1'b1;
      uyvy_order   = 1'b0;
      flip_rows    = 1'b0;
      row_pairs    = PairsRegW'(ResetPairs);
      frame_height = RowsRegW'(ResetRows);
      pair_pos     = 0;
      row_pos      = 0;
      expected_words.delete();
      words_pending_o <= 0;
      error_count_o   <= mismatches;
    end else begin
      // A word leaving at this edge always belongs to an older pair, so it is
      // checked before the pair accepted at the same edge is queued.
      if (word_i.valid && word_i.ready) check_word();
      if (pair_i.valid && pair_i.ready)
        expected_words.push_back(convert_pair(pair_i.luma_left, pair_i.luma_right,
                                              pair_i.chroma_u, pair_i.chroma_v));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPlanar: planar_src   = cfg_wdata_i[0];
          RegUyvy:   uyvy_order   = cfg_wdata_i[0];
          RegPairs:  row_pairs    = cfg_wdata_i[PairsRegW-1:0];
          RegRows:   frame_height = cfg_wdata_i[RowsRegW-1:0];
          RegFlip:   flip_rows    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      words_pending_o <= expected_words.size();
      error_count_o   <= mismatches;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import y2p_pkg::*;

  localparam int          HalfPeriod    = 10;
  localparam int          ResetCycles   = 4;
  localparam int unsigned QuietLimit    = 2000;
  localparam int          HoldCycles    = 64;
  localparam int unsigned RandomPairs   = 620;
  localparam int unsigned FillPairs     = 64;
  localparam int unsigned PressurePairs = 100;
  localparam int unsigned MaxExtent     = (1 << CfgW) - 1;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idling_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  int unsigned        error_count;
  int unsigned        words_pending;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  logic        hold_words      = 1'b0;
  int unsigned quiet_cycles    = 0;
  int unsigned pairs_sent      = 0;
  int unsigned phase_count     = 0;

  y2p_pair_if pair_ch ();
  y2p_word_if word_ch ();

  always #(HalfPeriod) clk = ~clk;

  yuv420_to_packed_422_converter_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pair_i      (pair_ch),
    .word_o      (word_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  packed_word_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .pair_i          (pair_ch),
    .word_i          (word_ch),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .error_count_o   (error_count),
    .words_pending_o (words_pending)
  );

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    word_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_words) begin
        word_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_words = 1'b0;
      end
      word_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pair_ch.valid && pair_ch.ready) || (word_ch.valid && word_ch.ready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no word moved for %0d cycles", quiet_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idling_e mode);
    case (mode)
      IdleNone:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IdleSender:   begin sender_idle_pct = 53; stall_pct = 0;  end
      IdleReceiver: begin sender_idle_pct = 0;  stall_pct = 53; end
      default:      begin sender_idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic send_pair(input logic [PixW-1:0] yl, input logic [PixW-1:0] yr,
                           input logic [PixW-1:0] cu, input logic [PixW-1:0] cv);
    while ($urandom_range(99) < sender_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pair_ch.valid      <= 1'b1;
    pair_ch.luma_left  <= yl;
    pair_ch.luma_right <= yr;
    pair_ch.chroma_u   <= cu;
    pair_ch.chroma_v   <= cv;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
    pairs_sent++;
  endtask

  function automatic logic [PixW-1:0] rand_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return PixW'($urandom);
  endfunction

  task automatic send_random_pairs(input int unsigned count);
    repeat (count) send_pair(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // Mostly small frames so that rows and frames end often.
  function automatic logic [CfgW-1:0] pick_extent(input int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return CfgW'($urandom_range(1, 6));
    if (roll < 88) return CfgW'($urandom_range(7, 24));
    if (roll < 94) return '0;
    return CfgW'($urandom_range(25, limit));
  endfunction

  // Widths stay within the stored chroma entries.
  task automatic randomize_regs();
    if ($urandom_range(99) < 40) write_reg(RegPlanar, CfgW'($urandom));
    if ($urandom_range(99) < 40) write_reg(RegUyvy, CfgW'($urandom));
    if ($urandom_range(99) < 40) write_reg(RegPairs, pick_extent(FillPairs));
    if ($urandom_range(99) < 40) write_reg(RegRows, pick_extent(MaxExtent));
    if ($urandom_range(99) < 40) write_reg(RegFlip, CfgW'($urandom));
    if ($urandom_range(99) < 10)
      write_reg(CfgIdxW'($urandom_range(int'(RegFlip) + 1, (1 << CfgIdxW) - 1)),
                CfgW'($urandom));
  endtask

  // Waits until every queued word has come back.
  task automatic drain();
    pair_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (3) @(posedge clk);
    phase_count++;
  endtask

  initial begin
    int unsigned random_sent;
    rst_n              = 1'b0;
    pair_ch.valid      = 1'b0;
    pair_ch.luma_left  = '0;
    pair_ch.luma_right = '0;
    pair_ch.chroma_u   = '0;
    pair_ch.chroma_v   = '0;
    cfg_we             = 1'b0;
    cfg_idx            = RegPlanar;
    cfg_wdata          = '0;
    random_sent        = 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One even row stores the first chroma entries. Later planar rows never
    // reach past them, so no odd row reads an entry that was never written.
    write_reg(RegPairs, CfgW'(FillPairs));
    write_reg(RegRows, 12'd2);
    cfg_we <= 1'b0;
    set_idling(IdleBoth);
    send_random_pairs(FillPairs);

    // Odd row reusing stored chroma, then an odd-height frame ending on an
    // even row. Input chroma on the odd row is ignored.
    drain();
    write_reg(RegRows, 12'd3);
    write_reg(RegPairs, 12'd2);
    write_reg(RegUyvy, 12'd0);
    write_reg(RegFlip, 12'd0);
    write_reg(RegPlanar, 12'd1);
    cfg_we <= 1'b0;
    send_pair(8'h00, 8'h00, 8'h00, 8'h00);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pair(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00, 8'hFF, 8'h00);

    // Zero width and height act as one: every word ends a frame.
    drain();
    write_reg(RegUyvy, 12'd1);
    write_reg(RegFlip, 12'd1);
    write_reg(RegPairs, 12'd0);
    write_reg(RegRows, 12'd0);
    cfg_we <= 1'b0;
    send_pair(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pair(8'h00, 8'hFF, 8'h00, 8'hFF);

    // Geometry shrunk in the middle of a row: the flipped row wraps.
    drain();
    write_reg(RegRows, 12'd4);
    write_reg(RegPairs, 12'd3);
    cfg_we <= 1'b0;
    send_random_pairs(5);
    drain();
    write_reg(RegPairs, 12'd1);
    write_reg(RegRows, 12'd1);
    cfg_we <= 1'b0;
    send_random_pairs(2);

    // Packed source, a write to an unused index, saturated height seen
    // through the flipped row.
    drain();
    write_reg(RegPlanar, 12'hFFE);
    write_reg(CfgIdxW'(int'(RegFlip) + 1), 12'hFFF);
    write_reg(RegRows, 12'hFFF);
    write_reg(RegPairs, 12'd1);
    cfg_we <= 1'b0;
    send_random_pairs(3);

    // The output holds off for a while, so that the queue fills and the
    // input stalls.
    set_idling(IdleNone);
    hold_words = 1'b1;
    send_random_pairs(PressurePairs);

    // Oversized width with a packed source, then one pair per row again so
    // that the pair position returns to zero.
    drain();
    write_reg(RegPairs, 12'h7FF);
    cfg_we <= 1'b0;
    send_random_pairs(5);
    drain();
    write_reg(RegPairs, 12'd1);
    cfg_we <= 1'b0;
    send_random_pairs(1);

    while (random_sent < RandomPairs) begin
      int unsigned count;
      drain();
      set_idling(idling_e'(phase_count % 4));
      randomize_regs();
      cfg_we <= 1'b0;
      count = $urandom_range(10, 60);
      send_random_pairs(count);
      random_sent += count;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d pixel pairs over %0d phases: both packing orders,", pairs_sent,
             phase_count);
    $display("planar and packed sources, flipped rows, degenerate and saturated geometry");
    if (error_count == 0 && words_pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d words missing", error_count, words_pending);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
